// File: hw/rtl/bee_pkg.sv
// Shared types, field widths, register indexes and masks for the exception entry block.
package bee_pkg;

  // Port widths
  localparam int S_TDATA_W   = 264;
  localparam int S_TUSER_W   = 4;
  localparam int M_TDATA_W   = 288;
  localparam int M_TUSER_W   = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Exception vector indexes handled here
  localparam logic [3:0] TYPE_EXTERNAL    = 4'd4;
  localparam logic [3:0] TYPE_SYSCALL     = 4'd8;
  localparam logic [3:0] TYPE_DECREMENTER = 4'd10;
  localparam logic [3:0] TYPE_DATA_TLB    = 4'd13;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_PREFIX      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_EXTERNAL    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_SYSCALL     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_DECREMENTER = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_DATA_TLB    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MISS_DEFAULTS      = 3'd5;

  // Register masks
  localparam logic [31:0] MSR_KEEP_MASK     = 32'h0002_1200;
  localparam logic [31:0] MSR_SYSCALL_CLEAR = 32'h0002_e930;
  localparam logic [31:0] TSR_DIS_BIT       = 32'h0800_0000;
  localparam logic [31:0] TLBSEL_BIT        = 32'h1000_0000;
  localparam logic [31:0] ESEL_CLEAR        = 32'hFFF0_FFFF;
  localparam logic [31:0] EPN_MASK          = 32'hFFFF_F000;
  localparam logic [31:0] TSIZE_MASK        = 32'h0000_0F00;
  localparam logic [31:0] PREFIX_MASK       = 32'hFFFF_0000;
  localparam logic [31:0] OFFSET_MASK       = 32'h0000_FFF0;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [15:0] vector_prefix;
    logic [15:0] offset_external;
    logic [15:0] offset_syscall;
    logic [15:0] offset_decrementer;
    logic [15:0] offset_data_tlb;
    logic [31:0] miss_defaults;
  } cfg_t;

  // One exception event
  typedef struct packed {
    logic [3:0]  exc_type;
    logic [31:0] cur_pc;
    logic [31:0] next_pc;
    logic [31:0] cur_msr;
    logic [31:0] cur_tsr;
    logic [31:0] fault_addr;
    logic [31:0] cur_mas0;
    logic [31:0] cur_mas1;
    logic [31:0] cur_mas3;
    logic        victim_bit;
  } in_item_t;

  // One result
  typedef struct packed {
    logic        fault;
    logic [31:0] save_pc;
    logic [31:0] save_msr;
    logic [31:0] new_msr;
    logic [31:0] new_tsr;
    logic        dear_valid;
    logic [31:0] dear_value;
    logic        mas_valid;
    logic [31:0] new_mas0;
    logic [31:0] new_mas1;
    logic [31:0] new_mas2;
    logic [31:0] vector_addr;
  } result_t;

endpackage

// File: hw/rtl/bee_cfg_regs.sv
// Configuration register file: vector prefix, per-type offsets and MAS4 defaults.
module bee_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bee_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bee_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bee_pkg::cfg_t                   cfg
);

  // Write decode; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bee_pkg::CFG_VECTOR_PREFIX:      cfg.vector_prefix      <= cfg_data[15:0];
        bee_pkg::CFG_OFFSET_EXTERNAL:    cfg.offset_external    <= cfg_data[15:0];
        bee_pkg::CFG_OFFSET_SYSCALL:     cfg.offset_syscall     <= cfg_data[15:0];
        bee_pkg::CFG_OFFSET_DECREMENTER: cfg.offset_decrementer <= cfg_data[15:0];
        bee_pkg::CFG_OFFSET_DATA_TLB:    cfg.offset_data_tlb    <= cfg_data[15:0];
        bee_pkg::CFG_MISS_DEFAULTS:      cfg.miss_defaults      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/bee_entry_logic.sv
// Combinational exception entry: SRR0/SRR1, MSR/TSR update, DEAR, MAS loads, vector.
module bee_entry_logic (
  input  bee_pkg::in_item_t item,
  input  bee_pkg::cfg_t     cfg,
  output bee_pkg::result_t  res
);

  logic [15:0] offset;
  logic        handled;
  logic [31:0] mas0_sel;

  always_comb begin
    res          = '0;
    res.new_msr  = item.cur_msr;
    res.new_tsr  = item.cur_tsr;
    res.new_mas0 = item.cur_mas0;
    res.new_mas1 = item.cur_mas1;
    offset       = '0;
    handled      = 1'b1;
    mas0_sel     = '0;

    case (item.exc_type)
      bee_pkg::TYPE_EXTERNAL: begin
        res.save_pc = item.next_pc;
        res.new_msr = item.cur_msr & bee_pkg::MSR_KEEP_MASK;
        offset      = cfg.offset_external;
      end
      bee_pkg::TYPE_SYSCALL: begin
        res.save_pc = item.next_pc;
        res.new_msr = item.cur_msr & ~bee_pkg::MSR_SYSCALL_CLEAR;
        offset      = cfg.offset_syscall;
      end
      bee_pkg::TYPE_DECREMENTER: begin
        res.save_pc = item.next_pc;
        res.new_msr = item.cur_msr & bee_pkg::MSR_KEEP_MASK;
        res.new_tsr = item.cur_tsr | bee_pkg::TSR_DIS_BIT;
        offset      = cfg.offset_decrementer;
      end
      bee_pkg::TYPE_DATA_TLB: begin
        res.save_pc    = item.cur_pc;
        res.new_msr    = item.cur_msr & bee_pkg::MSR_KEEP_MASK;
        res.dear_valid = 1'b1;
        res.dear_value = item.fault_addr;
        res.mas_valid  = 1'b1;
        // TLB select from MAS4; TLB0 also takes ESEL and NV from the victim bit
        mas0_sel = (cfg.miss_defaults & bee_pkg::TLBSEL_BIT) |
                   (item.cur_mas0 & ~bee_pkg::TLBSEL_BIT);
        if ((cfg.miss_defaults & bee_pkg::TLBSEL_BIT) == '0) begin
          mas0_sel     = (mas0_sel & bee_pkg::ESEL_CLEAR) |
                         {15'd0, item.victim_bit, 16'd0};
          mas0_sel[0]  = ~item.victim_bit;
        end
        res.new_mas0 = mas0_sel;
        res.new_mas1 = (cfg.miss_defaults & bee_pkg::TSIZE_MASK) |
                       (item.cur_mas1 & ~bee_pkg::TSIZE_MASK);
        res.new_mas2 = (item.fault_addr & bee_pkg::EPN_MASK) | {20'd0, item.cur_mas3[11:0]};
        offset       = cfg.offset_data_tlb;
      end
      default: begin
        handled   = 1'b0;
        res.fault = 1'b1;
      end
    endcase

    // Vector: prefix in the upper half, offset with its low nibble cleared; next_pc when unhandled
    if (handled) begin
      res.save_msr    = item.cur_msr;
      res.vector_addr = ({cfg.vector_prefix, 16'd0} & bee_pkg::PREFIX_MASK) |
                        ({16'd0, offset} & bee_pkg::OFFSET_MASK);
    end else begin
      res.vector_addr = item.next_pc;
    end
  end

endmodule

// File: hw/rtl/booke_exception_entry.sv
// Top level of the exception entry block: input register, entry logic, result register.
//
// Each transfer on the slave stream carries one exception event; one result leaves on the
// master stream after the event register and then the result register, and a new event
// can be taken every cycle unless the master side stalls. Throughput, without stalls, is
// one event per clock, set by the single pass of masking and selection between the two
// registers; a stalled master side holds both registers and drops s_tready only when both
// are full. Configuration writes take effect at the next clock and should be made while
// no event is in flight. Unhandled event types return fault with the incoming MSR, TSR,
// MAS0 and MAS1 passed through and the fetch address equal to next_pc.
module booke_exception_entry (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [bee_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bee_pkg::CFG_DATA_W-1:0]  cfg_data,
  // event stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, low bit up: cur_pc, next_pc, cur_msr, cur_tsr, fault_addr, cur_mas0,
  // cur_mas1, cur_mas3, victim_bit, 7 zero bits
  input  logic [bee_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: exc_type
  input  logic [bee_pkg::S_TUSER_W-1:0]   s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, low bit up: save_pc, save_msr, new_msr, new_tsr, dear_value, new_mas0,
  // new_mas1, new_mas2, vector_addr
  output logic [bee_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser, low bit up: fault, dear_valid, mas_valid
  output logic [bee_pkg::M_TUSER_W-1:0]   m_tuser
);

  bee_pkg::cfg_t     cfg;
  bee_pkg::in_item_t in_unpacked;
  bee_pkg::in_item_t in_item;
  bee_pkg::result_t  res;
  bee_pkg::result_t  out_item;
  logic              in_valid;
  logic              out_free;

  // Configuration registers
  bee_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the slave stream
  always_comb begin
    in_unpacked.exc_type   = s_tuser[3:0];
    in_unpacked.cur_pc     = s_tdata[31:0];
    in_unpacked.next_pc    = s_tdata[63:32];
    in_unpacked.cur_msr    = s_tdata[95:64];
    in_unpacked.cur_tsr    = s_tdata[127:96];
    in_unpacked.fault_addr = s_tdata[159:128];
    in_unpacked.cur_mas0   = s_tdata[191:160];
    in_unpacked.cur_mas1   = s_tdata[223:192];
    in_unpacked.cur_mas3   = s_tdata[255:224];
    in_unpacked.victim_bit = s_tdata[256];
  end

  // Two-register pipeline; each stage moves when the one after it can take data
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= in_unpacked;
    end
    if (in_valid && out_free) begin
      out_item <= res;
    end
  end

  // Entry computation
  bee_entry_logic u_logic (
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Pack the master stream
  assign m_tdata = {out_item.vector_addr, out_item.new_mas2, out_item.new_mas1,
                    out_item.new_mas0, out_item.dear_value, out_item.new_tsr,
                    out_item.new_msr, out_item.save_msr, out_item.save_pc};
  assign m_tuser = {out_item.mas_valid, out_item.dear_valid, out_item.fault};

  // An unhandled type never writes DEAR or the MAS registers
  a_fault_no_updates: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[2])
    else $error("fault result carries DEAR or MAS update");

  // MAS loads come only with a DEAR write (data TLB miss)
  a_mas_with_dear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1])
    else $error("MAS update without DEAR write");

  // An accepted event sits in the input register the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted event lost at input register");

  // A held event moves to the result register when it is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_free |=> m_tvalid)
    else $error("event did not reach result register");

endmodule

// File: bench/entry_checker.sv
// Checker for the exception entry block: tracks its registers, predicts each result, compares.
module entry_checker
  import bee_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // s_tdata, low bit up: cur_pc, next_pc, cur_msr, cur_tsr, fault_addr, cur_mas0,
  // cur_mas1, cur_mas3, victim_bit, 7 zero bits
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // s_tuser: exc_type
  input  logic [S_TUSER_W-1:0]   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata, low bit up: save_pc, save_msr, new_msr, new_tsr, dear_value, new_mas0,
  // new_mas1, new_mas2, vector_addr
  input  logic [M_TDATA_W-1:0]   m_tdata,
  // m_tuser, low bit up: fault, dear_valid, mas_valid
  input  logic [M_TUSER_W-1:0]   m_tuser,
  output int                     mismatches,
  output int                     in_flight
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] NV_CLEAR = 32'hFFFF_FFFE;

  cfg_t    shadow_regs;
  result_t expected_results[$];
  int      fail_count = 0;

  // Entry values for one exception event under the given register settings
  function automatic result_t expected_entry(in_item_t ev, cfg_t regs);
    result_t     r;
    logic [15:0] offset;
    logic        handled;
    r = '0;
    r.new_msr = ev.cur_msr;
    r.new_tsr = ev.cur_tsr;
    r.new_mas0 = ev.cur_mas0;
    r.new_mas1 = ev.cur_mas1;
    r.vector_addr = ev.next_pc;
    offset = '0;
    handled = 1'b1;
    case (ev.exc_type)
      TYPE_EXTERNAL: begin
        r.save_pc = ev.next_pc;
        r.new_msr = ev.cur_msr & MSR_KEEP_MASK;
        offset = regs.offset_external;
      end
      TYPE_SYSCALL: begin
        r.save_pc = ev.next_pc;
        r.new_msr = ev.cur_msr & ~MSR_SYSCALL_CLEAR;
        offset = regs.offset_syscall;
      end
      TYPE_DECREMENTER: begin
        r.save_pc = ev.next_pc;
        r.new_msr = ev.cur_msr & MSR_KEEP_MASK;
        r.new_tsr = ev.cur_tsr | TSR_DIS_BIT;
        offset = regs.offset_decrementer;
      end
      TYPE_DATA_TLB: begin
        r.save_pc = ev.cur_pc;
        r.new_msr = ev.cur_msr & MSR_KEEP_MASK;
        r.dear_valid = 1'b1;
        r.dear_value = ev.fault_addr;
        r.mas_valid = 1'b1;
        r.new_mas0 = (regs.miss_defaults & TLBSEL_BIT) | (ev.cur_mas0 & ~TLBSEL_BIT);
        // TLB0 selected: ESEL gets the victim way, NV its inverse
        if ((regs.miss_defaults & TLBSEL_BIT) == '0) begin
          r.new_mas0 = (r.new_mas0 & ESEL_CLEAR & NV_CLEAR)
                     | {15'd0, ev.victim_bit, 15'd0, ~ev.victim_bit};
        end
        r.new_mas1 = (regs.miss_defaults & TSIZE_MASK) | (ev.cur_mas1 & ~TSIZE_MASK);
        r.new_mas2 = (ev.fault_addr & EPN_MASK) | {20'd0, ev.cur_mas3[11:0]};
        offset = regs.offset_data_tlb;
      end
      default: begin
        handled = 1'b0;
        r.fault = 1'b1;
      end
    endcase
    if (handled) begin
      r.save_msr = ev.cur_msr;
      r.vector_addr = ({regs.vector_prefix, 16'd0} & PREFIX_MASK)
                    | ({16'd0, offset} & OFFSET_MASK);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Watch both streams and the register port
  always @(posedge clk) begin : watch
    in_item_t ev;
    result_t  got;
    result_t  want;
    if (rst) begin
      shadow_regs = '0;
      expected_results.delete();
    end else begin
      // result transfer: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.save_pc     = m_tdata[31:0];
        got.save_msr    = m_tdata[63:32];
        got.new_msr     = m_tdata[95:64];
        got.new_tsr     = m_tdata[127:96];
        got.dear_value  = m_tdata[159:128];
        got.new_mas0    = m_tdata[191:160];
        got.new_mas1    = m_tdata[223:192];
        got.new_mas2    = m_tdata[255:224];
        got.vector_addr = m_tdata[287:256];
        got.fault       = m_tuser[0];
        got.dear_valid  = m_tuser[1];
        got.mas_valid   = m_tuser[2];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h %h", $time, m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("fault", {31'd0, want.fault}, {31'd0, got.fault});
          check_field("save_pc", want.save_pc, got.save_pc);
          check_field("save_msr", want.save_msr, got.save_msr);
          check_field("new_msr", want.new_msr, got.new_msr);
          check_field("new_tsr", want.new_tsr, got.new_tsr);
          check_field("dear_valid", {31'd0, want.dear_valid}, {31'd0, got.dear_valid});
          check_field("dear_value", want.dear_value, got.dear_value);
          check_field("mas_valid", {31'd0, want.mas_valid}, {31'd0, got.mas_valid});
          check_field("new_mas0", want.new_mas0, got.new_mas0);
          check_field("new_mas1", want.new_mas1, got.new_mas1);
          check_field("new_mas2", want.new_mas2, got.new_mas2);
          check_field("vector_addr", want.vector_addr, got.vector_addr);
        end
      end
      // event transfer: predict its result
      if (s_tvalid && s_tready) begin
        ev.exc_type   = s_tuser;
        ev.cur_pc     = s_tdata[31:0];
        ev.next_pc    = s_tdata[63:32];
        ev.cur_msr    = s_tdata[95:64];
        ev.cur_tsr    = s_tdata[127:96];
        ev.fault_addr = s_tdata[159:128];
        ev.cur_mas0   = s_tdata[191:160];
        ev.cur_mas1   = s_tdata[223:192];
        ev.cur_mas3   = s_tdata[255:224];
        ev.victim_bit = s_tdata[256];
        expected_results.push_back(expected_entry(ev, shadow_regs));
      end
      // register writes; unused indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_VECTOR_PREFIX:      shadow_regs.vector_prefix = cfg_data[15:0];
          CFG_OFFSET_EXTERNAL:    shadow_regs.offset_external = cfg_data[15:0];
          CFG_OFFSET_SYSCALL:     shadow_regs.offset_syscall = cfg_data[15:0];
          CFG_OFFSET_DECREMENTER: shadow_regs.offset_decrementer = cfg_data[15:0];
          CFG_OFFSET_DATA_TLB:    shadow_regs.offset_data_tlb = cfg_data[15:0];
          CFG_MISS_DEFAULTS:      shadow_regs.miss_defaults = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches <= fail_count;
    in_flight <= expected_results.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the exception entry testbench: clock, reset, stimulus, stalls and the verdict.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import bee_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_CYCLES    = 10;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 220;

  // indexes past the last register; writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [S_TUSER_W-1:0]   s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [M_TUSER_W-1:0]   m_tuser;

  int mismatches;
  int in_flight;
  int cycles = 0;
  bit steady = 1'b0;        // no idling on either side
  bit hold_request = 1'b0;  // ask the receiver for one long hold-off

  booke_exception_entry dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  entry_checker entry_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
        hold_request = 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Mostly random words, with the all-zero and all-one corners now and then
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_event();
    in_item_t ev;
    case ($urandom_range(0, 9))
      0, 1:    ev.exc_type = TYPE_EXTERNAL;
      2, 3:    ev.exc_type = TYPE_SYSCALL;
      4, 5:    ev.exc_type = TYPE_DECREMENTER;
      6, 7:    ev.exc_type = TYPE_DATA_TLB;
      default: ev.exc_type = 4'($urandom_range(0, 15));
    endcase
    ev.cur_pc = rand_word();
    ev.next_pc = rand_word();
    ev.cur_msr = rand_word();
    ev.cur_tsr = rand_word();
    ev.fault_addr = rand_word();
    ev.cur_mas0 = rand_word();
    ev.cur_mas1 = rand_word();
    ev.cur_mas3 = rand_word();
    ev.victim_bit = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic cfg_t random_regs();
    cfg_t regs;
    regs.vector_prefix = 16'(rand_word());
    regs.offset_external = 16'(rand_word());
    regs.offset_syscall = 16'(rand_word());
    regs.offset_decrementer = 16'(rand_word());
    regs.offset_data_tlb = 16'(rand_word());
    regs.miss_defaults = rand_word();
    return regs;
  endfunction

  // One event transfer, after an optional idle burst
  task automatic send_event(in_item_t ev);
    int gap;
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ev.exc_type;
    s_tdata <= {7'd0, ev.victim_bit, ev.cur_mas3, ev.cur_mas1, ev.cur_mas0,
                ev.fault_addr, ev.cur_tsr, ev.cur_msr, ev.next_pc, ev.cur_pc};
    do @(posedge clk); while (!s_tready);
  endtask

  // Leaves the write enable high; the caller lowers it once
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // 16-bit registers get junk in the upper half, which must be ignored
  task automatic load_regs(cfg_t regs);
    write_reg(CFG_VECTOR_PREFIX, {16'($urandom), regs.vector_prefix});
    write_reg(CFG_OFFSET_EXTERNAL, {16'($urandom), regs.offset_external});
    write_reg(CFG_OFFSET_SYSCALL, {16'($urandom), regs.offset_syscall});
    write_reg(CFG_OFFSET_DECREMENTER, {16'($urandom), regs.offset_decrementer});
    write_reg(CFG_OFFSET_DATA_TLB, {16'($urandom), regs.offset_data_tlb});
    write_reg(CFG_MISS_DEFAULTS, regs.miss_defaults);
    write_reg(CFG_UNUSED_LO, $urandom);
    write_reg(CFG_UNUSED_HI, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    in_item_t ev;
    cfg_t     regs;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, TLB0 selected so the victim fields are written
    regs = random_regs();
    regs.miss_defaults = regs.miss_defaults & ~TLBSEL_BIT;
    load_regs(regs);
    for (int t = 0; t < 16; t++) begin
      ev = random_event();
      ev.exc_type = 4'(t);
      send_event(ev);
    end
    ev = '0;
    ev.exc_type = TYPE_DATA_TLB;
    send_event(ev);
    ev = '1;
    ev.exc_type = TYPE_DATA_TLB;
    send_event(ev);
    ev = '1;
    ev.exc_type = TYPE_EXTERNAL;
    send_event(ev);
    ev = '0;
    ev.exc_type = TYPE_DECREMENTER;
    send_event(ev);
    ev = '1;
    ev.exc_type = TYPE_SYSCALL;
    send_event(ev);
    wait_drained();

    // random phases, each under its own register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       regs = '1;
        3:       regs = '0;
        default: regs = random_regs();
      endcase
      load_regs(regs);
      steady = (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_request = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_event(random_event());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
